### rtl/kwl_pkg.sv
// Shared types, character codes and classification functions of the keyword token lexer.
`default_nettype none

package kwl_pkg;

    // Token kinds as carried on the result channel
    typedef enum logic [3:0] {
        KIND_IDENT    = 4'd0,
        KIND_RETURN   = 4'd1,
        KIND_I32      = 4'd2,
        KIND_U8       = 4'd3,
        KIND_LBRACE   = 4'd4,
        KIND_RBRACE   = 4'd5,
        KIND_LPAREN   = 4'd6,
        KIND_RPAREN   = 4'd7,
        KIND_LBRACKET = 4'd8,
        KIND_RBRACKET = 4'd9,
        KIND_SEMI     = 4'd10,
        KIND_COLON    = 4'd11,
        KIND_DOT      = 4'd12,
        KIND_COMMA    = 4'd13
    } t_kind;

    // One result token
    typedef struct packed {
        t_kind       kind;
        logic [31:0] start_offset;
        logic [15:0] length;
        logic [31:0] line;
        logic        run_end;
    } t_tok;

    // Results of one character: up to two tokens, count says how many are valid
    typedef struct packed {
        logic [1:0] count;
        t_tok       tok0;
        t_tok       tok1;
    } t_step_res;

    // Punctuation lookup result
    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_punct;

    localparam int unsigned PREFIX_BYTES = 6;
    localparam logic [15:0] MAX_WORD_LEN = 16'd65535;
    localparam logic [31:0] LINE_MAX     = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Packed word prefixes, first character in the low byte
    localparam logic [47:0] PFX_RETURN  = 48'h6E72_7574_6572;
    localparam logic [47:0] PFX_I32     = 48'h0000_0032_3369;
    localparam logic [47:0] PFX_U8      = 48'h0000_0000_3875;
    localparam logic [47:0] PFX_COMMENT = 48'h0000_0000_2F2F;

    function automatic t_punct punct_lookup(input logic [7:0] c);
        t_punct p;
        p.hit  = 1'b1;
        p.kind = KIND_IDENT;
        unique case (c)
            8'h7B:   p.kind = KIND_LBRACE;
            8'h7D:   p.kind = KIND_RBRACE;
            8'h28:   p.kind = KIND_LPAREN;
            8'h29:   p.kind = KIND_RPAREN;
            8'h5B:   p.kind = KIND_LBRACKET;
            8'h5D:   p.kind = KIND_RBRACKET;
            8'h3B:   p.kind = KIND_SEMI;
            8'h3A:   p.kind = KIND_COLON;
            8'h2E:   p.kind = KIND_DOT;
            8'h2C:   p.kind = KIND_COMMA;
            default: p.hit  = 1'b0;
        endcase
        return p;
    endfunction

    function automatic t_kind classify_word(input logic [15:0] len, input logic [47:0] pfx);
        t_kind k;
        priority if (len == 16'd6 && pfx == PFX_RETURN) begin
            k = KIND_RETURN;
        end else if (len == 16'd3 && pfx == PFX_I32) begin
            k = KIND_I32;
        end else if (len == 16'd2 && pfx == PFX_U8) begin
            k = KIND_U8;
        end else begin
            k = KIND_IDENT;
        end
        return k;
    endfunction

    function automatic logic is_comment_word(input logic [15:0] len, input logic [47:0] pfx);
        return (len == 16'd2) && (pfx == PFX_COMMENT);
    endfunction

endpackage

`default_nettype wire

### rtl/kwl_if.sv
// Handshake interfaces for the character input and the token output channels.
`default_nettype none

interface kwl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink   (input valid, input ch, input final_char, output ready);
endinterface

interface kwl_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] start_offset;
    logic [15:0] length;
    logic [31:0] line;
    logic        run_end;

    modport source (output valid, output kind, output start_offset, output length,
                    output line, output run_end, input ready);
    modport sink   (input valid, input kind, input start_offset, input length,
                    input line, input run_end, output ready);
endinterface

`default_nettype wire

### rtl/kwl_step.sv
// Lexer state and the per-character step that forms up to two tokens.
`default_nettype none

module kwl_step
    import kwl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_ch,
    input  wire logic       i_final_char,
    output t_step_res       o_res
);

    logic        r_in_comment, n_in_comment;
    logic        r_in_word, n_in_word;
    logic [31:0] r_word_start, n_word_start;
    logic [15:0] r_word_length, n_word_length;
    logic [47:0] r_word_prefix, n_word_prefix;
    logic [31:0] r_line_count, n_line_count;
    logic [31:0] r_position, n_position;

    t_punct      pk;
    logic        is_nl;
    logic        is_delim;
    logic [31:0] g_start;
    logic [15:0] g_len;
    logic [47:0] g_prefix;
    logic [31:0] e_start;
    logic [15:0] e_len;
    logic [47:0] e_prefix;
    logic        flush;
    logic        cmt;
    logic        word_emit;
    logic        punct_emit;
    logic [31:0] line_inc;
    t_tok        tok_word;
    t_tok        tok_punct;

    // Decode the character and grow the word
    always_comb begin
        pk       = punct_lookup(i_ch);
        is_nl    = (i_ch == CH_NEWLINE);
        is_delim = pk.hit || is_nl || (i_ch == CH_SPACE);
        line_inc = (r_line_count != LINE_MAX) ? r_line_count + 32'd1 : r_line_count;

        g_start = r_in_word ? r_word_start : r_position;
        if (!r_in_word) begin
            g_len    = 16'd1;
            g_prefix = {40'd0, i_ch};
        end else if (r_word_length < MAX_WORD_LEN) begin
            g_len    = r_word_length + 16'd1;
            g_prefix = r_word_prefix;
            for (int b = 0; b < PREFIX_BYTES; b++) begin
                if (r_word_length == 16'(b)) begin
                    g_prefix[8*b +: 8] = i_ch;
                end
            end
        end else begin
            // past the limit: never a keyword
            g_len    = r_word_length;
            g_prefix = '0;
        end

        // A delimiter ends the stored word; the last character ends the grown one
        e_start  = is_delim ? r_word_start  : g_start;
        e_len    = is_delim ? r_word_length : g_len;
        e_prefix = is_delim ? r_word_prefix : g_prefix;

        flush      = !r_in_comment && (is_delim ? r_in_word : i_final_char);
        cmt        = is_comment_word(e_len, e_prefix);
        word_emit  = flush && !cmt;
        punct_emit = !r_in_comment && pk.hit && !(flush && cmt);
    end

    // Next state
    always_comb begin
        n_in_comment  = r_in_comment;
        n_in_word     = r_in_word;
        n_word_start  = r_word_start;
        n_word_length = r_word_length;
        n_word_prefix = r_word_prefix;
        n_line_count  = r_line_count;
        n_position    = r_position + 32'd1;

        if (r_in_comment) begin
            if (is_nl) begin
                n_in_comment = 1'b0;
                n_line_count = line_inc;
            end
        end else if (is_delim) begin
            if (flush) begin
                // a newline closes a comment as soon as it opens
                n_in_comment  = cmt && !is_nl;
                n_in_word     = 1'b0;
                n_word_length = '0;
                n_word_prefix = '0;
            end
            if (is_nl) begin
                n_line_count = line_inc;
            end
        end else begin
            n_in_word     = 1'b1;
            n_word_start  = g_start;
            n_word_length = g_len;
            n_word_prefix = g_prefix;
            if (i_final_char) begin
                n_in_comment  = cmt;
                n_in_word     = 1'b0;
                n_word_length = '0;
                n_word_prefix = '0;
            end
        end
    end

    // Form the result tokens
    always_comb begin
        tok_word.kind         = classify_word(e_len, e_prefix);
        tok_word.start_offset = e_start;
        tok_word.length       = e_len;
        tok_word.line         = r_line_count;
        tok_word.run_end      = !punct_emit;

        tok_punct.kind         = pk.kind;
        tok_punct.start_offset = r_position;
        tok_punct.length       = 16'd1;
        tok_punct.line         = r_line_count;
        tok_punct.run_end      = 1'b1;

        o_res.count = {1'b0, word_emit} + {1'b0, punct_emit};
        o_res.tok0  = word_emit ? tok_word : tok_punct;
        o_res.tok1  = tok_punct;
    end

    // Advance state on each processed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment  <= 1'b0;
            r_in_word     <= 1'b0;
            r_word_start  <= '0;
            r_word_length <= '0;
            r_word_prefix <= '0;
            r_line_count  <= 32'd1;
            r_position    <= '0;
        end else if (i_fire) begin
            r_in_comment  <= n_in_comment;
            r_in_word     <= n_in_word;
            r_word_start  <= n_word_start;
            r_word_length <= n_word_length;
            r_word_prefix <= n_word_prefix;
            r_line_count  <= n_line_count;
            r_position    <= n_position;
        end
    end

endmodule

`default_nettype wire

### rtl/kwl_res_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
`default_nettype none

module kwl_res_fifo
    import kwl_pkg::*;
#(
    parameter int unsigned DEPTH = 4  // power of two, at least 4
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push_en,
    input  wire t_step_res i_push,
    input  wire logic      i_pop,
    output t_tok           o_head,
    output logic           o_valid,
    output logic           o_room2
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = AW + 1;

    t_tok            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   push_n;
    logic            pop;

    always_comb begin
        push_n   = i_push_en ? CW'(i_push.count) : '0;
        pop      = i_pop && o_valid;
        n_wr_ptr = r_wr_ptr + AW'(push_n);
        n_rd_ptr = r_rd_ptr + AW'(pop);
        n_count  = r_count + push_n - CW'(pop);
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));

    // Store pushed tokens
    always_ff @(posedge i_clk) begin
        if (i_push_en && i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push_en && i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_push.tok1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/keyword_token_lexer.sv
// Top level of the keyword token lexer: input register, lexer step and result queue.
//
// Usage:
//   i_char carries one source byte per transfer (ch) and a flag for the last
//   byte of the text (final_char). o_tok carries tokens: kind, start offset,
//   length, line and run_end, which marks the last token of one character.
//   A character yields zero, one or two tokens (a flushed word, then a
//   punctuation token).
// Timing:
//   A character is registered on transfer and processed from the input
//   register once the queue has room; its tokens go into the queue and are
//   offered from its head. One character is taken per cycle while the queue
//   has room; the queue (OUT_DEPTH entries) absorbs two-token characters,
//   so that rate holds while the tokens average at most one per cycle.
// Reset:
//   Synchronous active-low reset empties the queue, sets the line to 1 and
//   the offset to 0.
// Backpressure:
//   When o_tok stalls, the queue fills; once fewer than two entries are free
//   the input register holds its character and i_char.ready drops.
`default_nettype none

module keyword_token_lexer
    import kwl_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kwl_char_if.sink   i_char,
    kwl_tok_if.source  o_tok
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_fin;
    logic       room2;
    logic       process;
    logic       accept;
    t_step_res  step_res;
    t_tok       head;
    logic       head_valid;

    assign process      = r_in_valid && room2;
    assign i_char.ready = !r_in_valid || process;
    assign accept       = i_char.valid && i_char.ready;

    // Hold the incoming character until the step takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch  <= i_char.ch;
            r_fin <= i_char.final_char;
        end
    end

    kwl_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (process),
        .i_ch         (r_ch),
        .i_final_char (r_fin),
        .o_res        (step_res)
    );

    kwl_res_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (process),
        .i_push    (step_res),
        .i_pop     (o_tok.ready),
        .o_head    (head),
        .o_valid   (head_valid),
        .o_room2   (room2)
    );

    // Drive the token channel from the queue head
    assign o_tok.valid        = head_valid;
    assign o_tok.kind         = head.kind;
    assign o_tok.start_offset = head.start_offset;
    assign o_tok.length       = head.length;
    assign o_tok.line         = head.line;
    assign o_tok.run_end      = head.run_end;

    // No token offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_tok.valid)
        else $error("token offered right after reset");

    // A two-token character marks only its second token as the last
    a_two_tok_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && step_res.count == 2'd2) |-> (!step_res.tok0.run_end && step_res.tok1.run_end))
        else $error("run_end misplaced on two-token character");

    // A held character stays in the input register until processed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !process) |=> (r_in_valid && $stable(r_ch) && $stable(r_fin)))
        else $error("held character lost");

    // A processed character with no room would overflow the queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room2) |=> r_in_valid)
        else $error("character processed without queue room");

endmodule

`default_nettype wire

### tb/sv/kwl_token_checker.sv
// Token checker for the keyword token lexer: predicts tokens per character and compares them.
module kwl_token_checker
    import kwl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    kwl_char_if  i_char,
    kwl_tok_if   i_tok,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Word prefixes, first character in the low byte (string literals read right to left)
    localparam logic [47:0] KW_RETURN  = "nruter";
    localparam logic [47:0] KW_I32     = {24'd0, "23i"};
    localparam logic [47:0] KW_U8      = {32'd0, "8u"};
    localparam logic [47:0] KW_SLASHES = {32'd0, "//"};

    // Lexer state as seen by the predictor
    logic        in_cmt;
    logic        in_wrd;
    logic [31:0] wrd_start;
    logic [15:0] wrd_len;
    logic [47:0] wrd_pfx;
    logic [31:0] line_no;
    logic [31:0] next_pos;

    t_tok tok_expect_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_tok make_tok(input t_kind k, input logic [31:0] start,
                                      input logic [15:0] len, input logic [31:0] ln);
        t_tok t;
        t.kind         = k;
        t.start_offset = start;
        t.length       = len;
        t.line         = ln;
        t.run_end      = 1'b0;
        return t;
    endfunction

    function automatic logic punct_kind_of(input logic [7:0] c, output t_kind k);
        k = KIND_IDENT;
        case (c)
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            "[": k = KIND_LBRACKET;
            "]": k = KIND_RBRACKET;
            ";": k = KIND_SEMI;
            ":": k = KIND_COLON;
            ".": k = KIND_DOT;
            ",": k = KIND_COMMA;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Advance the line, holding at the top value
    function automatic void bump_line();
        if (line_no != '1) begin
            line_no = line_no + 32'd1;
        end
    endfunction

    // End the open word; a word equal to // opens a comment instead of making a token
    function automatic logic close_word(output t_tok w);
        t_kind k;
        w = '0;
        if (!in_wrd) begin
            return 1'b0;
        end
        in_wrd = 1'b0;
        if (wrd_len == 16'd2 && wrd_pfx == KW_SLASHES) begin
            in_cmt  = 1'b1;
            wrd_len = '0;
            wrd_pfx = '0;
            return 1'b0;
        end
        k = KIND_IDENT;
        if (wrd_len == 16'd6 && wrd_pfx == KW_RETURN) begin
            k = KIND_RETURN;
        end else if (wrd_len == 16'd3 && wrd_pfx == KW_I32) begin
            k = KIND_I32;
        end else if (wrd_len == 16'd2 && wrd_pfx == KW_U8) begin
            k = KIND_U8;
        end
        w       = make_tok(k, wrd_start, wrd_len, line_no);
        wrd_len = '0;
        wrd_pfx = '0;
        return 1'b1;
    endfunction

    // Lex one character and queue the tokens it produces
    function automatic void lex_char(input logic [7:0] c, input logic fin);
        t_tok  step_q[$];
        t_tok  w;
        t_kind pk;
        logic  is_punct;
        logic [31:0] here;
        here     = next_pos;
        next_pos = next_pos + 32'd1;
        is_punct = punct_kind_of(c, pk);

        // Drop everything inside a comment; newline closes it
        if (in_cmt) begin
            if (c == CH_NEWLINE) begin
                in_cmt = 1'b0;
                bump_line();
            end
            return;
        end

        if (is_punct || c == CH_SPACE || c == CH_NEWLINE) begin
            if (close_word(w)) begin
                step_q.push_back(w);
            end
            if (in_cmt) begin
                // Delimiter right after // belongs to the comment
                if (c == CH_NEWLINE) begin
                    in_cmt = 1'b0;
                    bump_line();
                end
            end else begin
                if (is_punct) begin
                    step_q.push_back(make_tok(pk, here, 16'd1, line_no));
                end
                if (c == CH_NEWLINE) begin
                    bump_line();
                end
            end
        end else begin
            // Grow the word; past the length limit clear the prefix
            if (!in_wrd) begin
                in_wrd    = 1'b1;
                wrd_start = here;
                wrd_len   = 16'd1;
                wrd_pfx   = {40'd0, c};
            end else if (wrd_len < MAX_WORD_LEN) begin
                if (wrd_len < 16'd6) begin
                    wrd_pfx[int'(wrd_len) * 8 +: 8] = c;
                end
                wrd_len = wrd_len + 16'd1;
            end else begin
                wrd_pfx = '0;
            end
            if (fin && close_word(w)) begin
                step_q.push_back(w);
            end
        end

        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].run_end = 1'b1;
        end
        foreach (step_q[i]) begin
            tok_expect_q.push_back(step_q[i]);
        end
    endfunction

    // Compare token transfers first, then predict from character transfers
    always @(posedge i_clk) begin
        t_tok got;
        t_tok want;
        if (!i_rst_n) begin
            in_cmt    = 1'b0;
            in_wrd    = 1'b0;
            wrd_start = '0;
            wrd_len   = '0;
            wrd_pfx   = '0;
            line_no   = 32'd1;
            next_pos  = '0;
            tok_expect_q.delete();
        end else begin
            if (i_tok.valid && i_tok.ready) begin
                got.kind         = t_kind'(i_tok.kind);
                got.start_offset = i_tok.start_offset;
                got.length       = i_tok.length;
                got.line         = i_tok.line;
                got.run_end      = i_tok.run_end;
                if (tok_expect_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: unexpected token kind=%0d start=%0d len=%0d line=%0d end=%0b",
                                 $realtime, got.kind, got.start_offset, got.length, got.line,
                                 got.run_end);
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = tok_expect_q.pop_front();
                    if (got.kind !== want.kind || got.start_offset !== want.start_offset ||
                        got.length !== want.length || got.line !== want.line ||
                        got.run_end !== want.run_end) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: token mismatch exp kind=%0d start=%0d len=%0d line=%0d end=%0b",
                                     $realtime, want.kind, want.start_offset, want.length,
                                     want.line, want.run_end);
                            $display("%0t:                got kind=%0d start=%0d len=%0d line=%0d end=%0b",
                                     $realtime, got.kind, got.start_offset, got.length,
                                     got.line, got.run_end);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_char.valid && i_char.ready) begin
                lex_char(i_char.ch, i_char.final_char);
            end
        end
        o_pending = tok_expect_q.size();
    end

endmodule

### tb/sv/tb_keyword_token_lexer.sv
// Testbench top for the keyword token lexer: clock, reset, source text stimulus and verdict.
module tb_keyword_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;
    import kwl_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic idle_on;
    int   fail_count;
    int   pending;
    int   lexed_count;
    logic in_comment_text;

    logic [7:0] src_ch[$];
    logic       src_fin[$];

    string punct_chars   = "{}()[];:.,";
    string near_miss [8] = '{"retur", "returns", "i3", "i322", "u", "u88", "///", "I32"};

    kwl_char_if char_bus ();
    kwl_tok_if  tok_bus ();

    keyword_token_lexer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_bus),
        .o_tok   (tok_bus)
    );

    kwl_token_checker token_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_char       (char_bus),
        .i_tok        (tok_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop for a hung run
    initial begin
        #200_000_000;
        $display("tb_keyword_token_lexer: errors");
        $finish;
    end

    // Token sink: random stall bursts while idling is on
    initial begin
        int stall_left;
        stall_left  = 0;
        tok_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
            if (stall_left > 0) begin
                tok_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                tok_bus.ready <= 1'b1;
            end
        end
    end

    function automatic logic is_delim(input logic [7:0] b);
        return b inside {"{", "}", "(", ")", "[", "]", ";", ":", ".", ",",
                         CH_SPACE, CH_NEWLINE};
    endfunction

    // Mostly lowercase letters, otherwise any non-delimiter byte
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0) begin
            return 8'h61 + 8'($urandom_range(0, 25));
        end
        do begin
            b = 8'($urandom_range(0, 255));
        end while (is_delim(b));
        return b;
    endfunction

    function automatic logic [7:0] any_delim();
        int k;
        k = $urandom_range(0, 11);
        if (k == 10) begin
            return CH_SPACE;
        end else if (k == 11) begin
            return CH_NEWLINE;
        end
        return punct_chars[k];
    endfunction

    function automatic void add_char(input logic [7:0] c, input logic fin);
        src_ch.push_back(c);
        src_fin.push_back(fin);
        if (!in_comment_text) begin
            lexed_count++;
        end
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i], 1'b0);
        end
    endfunction

    function automatic void mark_last_final();
        src_fin[src_fin.size() - 1] = 1'b1;
    endfunction

    // Build one piece of source text: tokens with random content, some noise
    function automatic void add_snippet();
        int ntok;
        int k;
        int len;
        logic [7:0] b;
        ntok = $urandom_range(3, 20);
        repeat (ntok) begin
            k = $urandom_range(0, 11);
            case (k)
                0: add_text("return");
                1: add_text("i32");
                2: add_text("u8");
                3: add_text(near_miss[$urandom_range(0, 7)]);
                4, 5: begin
                    len = $urandom_range(1, 8);
                    repeat (len) add_char(word_byte(), 1'b0);
                end
                6, 7: add_char(punct_chars[$urandom_range(0, 9)], 1'b0);
                8: add_char(CH_SPACE, 1'b0);
                9: add_char(CH_NEWLINE, 1'b0);
                10: begin
                    // Comment: body of any bytes but newline, then newline
                    add_text("//");
                    len = $urandom_range(0, 8);
                    in_comment_text = 1'b1;
                    repeat (len) begin
                        do begin
                            b = 8'($urandom_range(0, 255));
                        end while (b == CH_NEWLINE);
                        add_char(b, $urandom_range(0, 7) == 0);
                    end
                    in_comment_text = 1'b0;
                    add_char(CH_NEWLINE, 1'b0);
                end
                default: begin
                    len = $urandom_range(1, 6);
                    repeat (len) add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
            endcase
            // Separate words mostly; leave some glued together
            if (k <= 5 && $urandom_range(0, 5) != 0) begin
                add_char(any_delim(), 1'b0);
            end
        end
        if ($urandom_range(0, 4) != 0) begin
            mark_last_final();
        end
    endfunction

    // Drive one character and hold it until the transfer
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        char_bus.valid      <= 1'b1;
        char_bus.ch         <= c;
        char_bus.final_char <= fin;
        do begin
            @(posedge clk);
        end while (!char_bus.ready);
        @(negedge clk);
    endtask

    task automatic send_queued();
        while (src_ch.size() > 0) begin
            send_char(src_ch.pop_front(), src_fin.pop_front());
        end
    endtask

    initial begin
        char_bus.valid      = 1'b0;
        char_bus.ch         = 8'h00;
        char_bus.final_char = 1'b0;
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        in_comment_text     = 1'b0;
        lexed_count         = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: keywords, every punctuation, comment forms, final flush
        add_text("return{i32}u8(;)[]:.,");
        add_text("//;x");
        add_char(CH_NEWLINE, 1'b0);
        add_text("//");
        add_char(CH_NEWLINE, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b1);
        add_char(".", 1'b1);
        send_queued();

        // Hold the sender until every token has drained
        char_bus.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);

        // Random source text; idle in stretches, none in the last part
        lexed_count = 0;
        while (lexed_count < 800) begin
            idle_on = (lexed_count < 650) && ((lexed_count / 90) % 4 != 3);
            add_snippet();
            send_queued();
        end
        idle_on = 1'b0;
        char_bus.valid <= 1'b0;

        // Drain and let any late token show up
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0) begin
            $display("tb_keyword_token_lexer: clean");
        end else begin
            $display("tb_keyword_token_lexer: errors");
        end
        $finish;
    end

endmodule
